// ===== src/cfp_pkg.sv =====
`timescale 1ns / 1ps
package cfp_pkg;

   localparam logic [7:0] HDR0_BYTE = 8'hA5;
   localparam logic [7:0] HDR1_BYTE = 8'h5A;
   localparam logic [7:0] TRL0_BYTE = 8'hB6;
   localparam logic [7:0] TRL1_BYTE = 8'h6B;
   localparam logic [7:0] SHORT_LEN = 8'h01;
   localparam logic [7:0] SHORT_DATA = 8'h00;
   localparam logic [7:0] SERIAL_LEN = 8'h04;
   localparam logic [3:0] BCD_MAX = 4'h9;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd6;
   localparam int SHORT_FRAME_BYTES = 7;
   localparam int MIN_DONE_BYTES = 6;
   localparam int PAYLOAD_KEEP = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_COLOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_BRIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTART = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_QUERY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_SERIAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_SERIAL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GET_SERIAL = 3'd6;

   localparam int RSP_DATA_W = 64;

   typedef enum logic [2:0] {
      ACT_LIGHT         = 3'd0,
      ACT_RESTART       = 3'd1,
      ACT_KEY_QUERY     = 3'd2,
      ACT_SERIAL_OK     = 3'd3,
      ACT_SERIAL_REJECT = 3'd4,
      ACT_SERIAL_RESET  = 3'd5,
      ACT_SERIAL_GET    = 3'd6,
      ACT_OTHER         = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      KIND_NORMAL    = 2'd0,
      KIND_RESTART   = 2'd1,
      KIND_KEY_QUERY = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] light_color;
      logic [7:0] light_bright;
      logic [7:0] restart;
      logic [7:0] key_query;
      logic [7:0] set_serial;
      logic [7:0] reset_serial;
      logic [7:0] get_serial;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] command;
      logic [7:0] length;
      logic [PAYLOAD_KEEP-1:0][7:0] payload;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/cfp_front.sv =====
`timescale 1ns / 1ps
module cfp_front import cfp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_valid,
   output logic       byte_ready,
   input  logic [7:0] rx_byte,
   input  logic       queue_full,
   output logic       push,
   output frame_type  push_frame
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_next;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] prev_ff;
   logic [PAYLOAD_KEEP-1:0][7:0] pay_ff, pay_in;
   logic accept;
   logic trailer_ok;
   logic short_body;
   kind_type kind;
   logic found;

   assign byte_ready = !queue_full;
   assign accept = byte_valid && byte_ready;
   assign trailer_ok = (prev_ff == TRL0_BYTE) && (rx_byte == TRL1_BYTE);
   // Fixed seven-byte frames: one payload byte of zero, then the trailer.
   assign short_body = (len_ff == SHORT_LEN) && (pay_ff[0] == SHORT_DATA) && trailer_ok;

   always_comb begin
      cnt_next = cnt_ff + CNT_W'(1);
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      pay_in = pay_ff;
      found = 1'b0;
      kind = KIND_NORMAL;
      if (cnt_ff == CNT_W'(0)) begin
         cnt_in = (rx_byte == HDR0_BYTE) ? CNT_W'(1) : CNT_W'(0);
      end else if (cnt_ff == CNT_W'(1)) begin
         cnt_in = (rx_byte == HDR1_BYTE) ? CNT_W'(2) : CNT_W'(0);
      end else begin
         if (cnt_ff == CNT_W'(2)) begin
            cmd_in = rx_byte;
         end else if (cnt_ff == CNT_W'(3)) begin
            len_in = rx_byte;
         end else if (cnt_ff >= CNT_W'(4) && cnt_ff <= CNT_W'(7)) begin
            pay_in[cnt_ff[1:0]] = rx_byte;
         end
         cnt_in = cnt_next;
         priority if (cnt_next == CNT_W'(SHORT_FRAME_BYTES) && short_body &&
                      cmd_ff == cfg.restart) begin
            found = 1'b1;
            kind = KIND_RESTART;
            cnt_in = CNT_W'(0);
         end else if (cnt_next == CNT_W'(SHORT_FRAME_BYTES) && short_body &&
                      cmd_ff == cfg.key_query) begin
            found = 1'b1;
            kind = KIND_KEY_QUERY;
            cnt_in = CNT_W'(0);
         end else if (cnt_next >= CNT_W'(MIN_DONE_BYTES) &&
                      8'(cnt_next) == 8'(len_ff + FRAME_OVERHEAD)) begin
            // The frame ends at its target count even when the trailer is wrong.
            found = trailer_ok;
            cnt_in = CNT_W'(0);
         end else if (cnt_next > CNT_W'(MAX_FRAME_BYTES)) begin
            cnt_in = CNT_W'(0);
         end else begin
            cnt_in = cnt_next;
         end
      end
   end

   assign push = accept && found;
   assign push_frame = '{kind: kind, command: cmd_in, length: len_in, payload: pay_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         cmd_ff <= '0;
         len_ff <= '0;
         prev_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
         prev_ff <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pay_ff <= pay_in;
      end
   end

endmodule

// ===== src/cfp_queue.sv =====
`timescale 1ns / 1ps
module cfp_queue import cfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_frame,
   input  logic             pop,
   output frame_type        head_frame,
   output queue_status_type status
);

   frame_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head_frame = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== src/cfp_back.sv =====
`timescale 1ns / 1ps
module cfp_back import cfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  queue_empty,
   input  frame_type             head_frame,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output action_type            action,
   output logic [7:0]            command,
   output logic [7:0]            length,
   output logic [7:0]            first_data,
   output logic [31:0]           serial_value
);

   logic valid_ff;
   action_type action_ff, action_in;
   logic [7:0] command_ff, length_ff, first_ff;
   logic [31:0] serial_ff, serial_in;
   logic bcd_ok;
   logic [7:0] cmd;

   assign cmd = head_frame.command;
   assign pop = !queue_empty && (!valid_ff || rsp_ready);

   always_comb begin
      bcd_ok = 1'b1;
      for (int i = 0; i < PAYLOAD_KEEP; i++) begin
         if (head_frame.payload[i][7:4] > BCD_MAX || head_frame.payload[i][3:0] > BCD_MAX) begin
            bcd_ok = 1'b0;
         end
      end
   end

   always_comb begin
      serial_in = '0;
      action_in = ACT_OTHER;
      unique case (head_frame.kind)
         KIND_RESTART: action_in = ACT_RESTART;
         KIND_KEY_QUERY: action_in = ACT_KEY_QUERY;
         default: begin
            // Opcodes may coincide; the earlier match wins.
            priority if (cmd == cfg.light_color || cmd == cfg.light_bright) begin
               action_in = ACT_LIGHT;
            end else if (cmd == cfg.set_serial) begin
               if (head_frame.length == SERIAL_LEN && bcd_ok) begin
                  action_in = ACT_SERIAL_OK;
                  serial_in = {head_frame.payload[0], head_frame.payload[1],
                               head_frame.payload[2], head_frame.payload[3]};
               end else begin
                  action_in = ACT_SERIAL_REJECT;
               end
            end else if (cmd == cfg.reset_serial) begin
               action_in = ACT_SERIAL_RESET;
            end else if (cmd == cfg.get_serial) begin
               action_in = ACT_SERIAL_GET;
            end else begin
               action_in = ACT_OTHER;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff <= action_in;
         command_ff <= cmd;
         length_ff <= head_frame.length;
         first_ff <= head_frame.payload[0];
         serial_ff <= serial_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign action = action_ff;
   assign command = command_ff;
   assign length = length_ff;
   assign first_data = first_ff;
   assign serial_value = serial_ff;

endmodule

// ===== src/command_frame_parser.sv =====
`timescale 1ns / 1ps
// Result path: once the trailer byte is accepted, its frame is written into the
// frame queue and then loaded into the output register that drives the result word.
// Throughput: one byte per cycle; the front stalls only when its two-entry
// frame queue is full, which takes results held back by rsp_tready.
// Reset: synchronous, active high; clears the frame hunt, the queue and the
// output register, and loads the opcode registers with their defaults.
module command_frame_parser import cfp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] rx_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [2:0] action, [10:3] command, [18:11] length, [26:19] first_data,
   // [58:27] serial_value, [63:59] zero
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]              csr_data
);

   cfg_type cfg_ff;
   logic push, pop;
   frame_type push_frame, head_frame;
   queue_status_type q_status;
   action_type action;
   logic [7:0] command, length, first_data;
   logic [31:0] serial_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{light_color: 8'd1, light_bright: 8'd2, restart: 8'd32,
                     key_query: 8'd33, set_serial: 8'd17, reset_serial: 8'd18,
                     get_serial: 8'd19};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LIGHT_COLOR: cfg_ff.light_color <= csr_data;
            CSR_LIGHT_BRIGHT: cfg_ff.light_bright <= csr_data;
            CSR_RESTART: cfg_ff.restart <= csr_data;
            CSR_KEY_QUERY: cfg_ff.key_query <= csr_data;
            CSR_SET_SERIAL: cfg_ff.set_serial <= csr_data;
            CSR_RESET_SERIAL: cfg_ff.reset_serial <= csr_data;
            CSR_GET_SERIAL: cfg_ff.get_serial <= csr_data;
            default: ;
         endcase
      end
   end

   cfp_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .byte_valid(req_tvalid),
      .byte_ready(req_tready),
      .rx_byte(req_tdata),
      .queue_full(q_status.full),
      .push(push),
      .push_frame(push_frame)
   );

   cfp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_frame(push_frame),
      .pop(pop),
      .head_frame(head_frame),
      .status(q_status)
   );

   cfp_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .queue_empty(q_status.empty),
      .head_frame(head_frame),
      .pop(pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .action(action),
      .command(command),
      .length(length),
      .first_data(first_data),
      .serial_value(serial_value)
   );

   assign rsp_tdata = {5'd0, serial_value, first_data, length, command, action};

`ifndef ASSERT_OFF
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("frame queue reports full and empty at once");

   a_ready_follows_queue: assert property (@(posedge clock) disable iff (reset)
      req_tready == !q_status.full)
      else $error("byte ready does not follow queue space");

   a_serial_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && action != ACT_SERIAL_OK |-> serial_value == '0)
      else $error("serial value set on a word that is not a serial write");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");
`endif

endmodule
